FILE: rtl/preamble_sync_byte_deframer_assert.svh
// Assertion macros shared by the deframer checker.
// Holds only macro definitions; the checker module includes it.
`ifndef PREAMBLE_SYNC_BYTE_DEFRAMER_ASSERT_SVH
`define PREAMBLE_SYNC_BYTE_DEFRAMER_ASSERT_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define PSBD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, with the rule applied only when a qualifier holds.
`define PSBD_ASSERT_IF(label, clk, rst_n, cond, prop, msg) \
  `PSBD_ASSERT(label, clk, rst_n, (cond) |-> (prop), msg)

`endif

FILE: rtl/psbd_pkg.sv
// Package for the preamble sync byte deframer: widths, reset constants and
// the structs passed between its stages. No dependencies.
`default_nettype none

package psbd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HELD_W = 4;

  localparam logic [BYTE_W-1:0] PREAMBLE_RESET = 8'hAB;
  localparam logic [HELD_W-1:0] BYTE_BITS      = 4'd8;
  localparam logic [BYTE_W-1:0] ZERO_BYTE      = '0;

  // One accepted line bit waiting in the input register.
  typedef struct packed {
    logic valid;
    logic rx_bit;
  } in_item_t;

  // Result produced by the core for the output register.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/psbd_in_reg.sv
// Input register of the deframer: captures one line bit per transfer.
// Depends on psbd_pkg.
`default_nettype none

module psbd_in_reg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  input  wire logic              s_bit_i,
  input  wire logic              advance_i,
  output logic                   s_ready_o,
  output psbd_pkg::in_item_t     item_o
);

  logic valid_q, valid_d;
  logic bit_q;
  logic load;

  // The held bit leaves whenever the output side can take a result.
  assign s_ready_o = !valid_q || advance_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bit_q <= s_bit_i;
    end
  end

  assign item_o.valid  = valid_q;
  assign item_o.rx_bit = bit_q;

endmodule

`default_nettype wire

FILE: rtl/psbd_core.sv
// Deframer core: preamble register, hunt/data mode, bit shifter and count.
// Depends on psbd_pkg.
`default_nettype none

module psbd_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [psbd_pkg::BYTE_W-1:0]   cfg_wdata_i,
  input  wire psbd_pkg::in_item_t            item_i,
  input  wire logic                          advance_i,
  output psbd_pkg::result_t                  result_o
);

  logic [psbd_pkg::BYTE_W-1:0] preamble_q;
  logic                        data_mode_q, data_mode_d;
  logic [psbd_pkg::BYTE_W-1:0] shifter_q, shifter_d;
  logic [psbd_pkg::HELD_W-1:0] held_q, held_d;
  logic [psbd_pkg::BYTE_W-1:0] shifted;
  logic [psbd_pkg::HELD_W-1:0] held_inc;
  logic                        full;
  logic                        step;

  assign step     = item_i.valid && advance_i;
  assign shifted  = {shifter_q[psbd_pkg::BYTE_W-2:0], item_i.rx_bit};
  // In hunt mode the count saturates at eight; in data mode it never passes it.
  assign held_inc = (held_q < psbd_pkg::BYTE_BITS) ? held_q + 4'd1 : held_q;
  assign full     = (held_inc == psbd_pkg::BYTE_BITS);

  always_comb begin
    data_mode_d              = data_mode_q;
    shifter_d                = shifted;
    held_d                   = held_inc;
    result_o.valid           = 1'b0;
    result_o.data_byte       = shifted;
    result_o.end_of_message  = (shifted == psbd_pkg::ZERO_BYTE);
    if (!data_mode_q) begin
      if (full && (shifted == preamble_q)) begin
        data_mode_d = 1'b1;
        shifter_d   = '0;
        held_d      = '0;
      end
    end else if (full) begin
      result_o.valid = item_i.valid;
      if (shifted == psbd_pkg::ZERO_BYTE) begin
        data_mode_d = 1'b0;
      end
      shifter_d = '0;
      held_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q  <= psbd_pkg::PREAMBLE_RESET;
      data_mode_q <= 1'b0;
      shifter_q   <= '0;
      held_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        preamble_q <= cfg_wdata_i;
      end
      if (step) begin
        data_mode_q <= data_mode_d;
        shifter_q   <= shifter_d;
        held_q      <= held_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psbd_out_reg.sv
// Output register of the deframer: holds one byte until the sink takes it.
// Depends on psbd_pkg.
`default_nettype none

module psbd_out_reg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire psbd_pkg::result_t             result_i,
  input  wire logic                          m_ready_i,
  output logic                               free_o,
  output logic                               m_valid_o,
  output logic [psbd_pkg::BYTE_W-1:0]        m_data_o,
  output logic                               m_last_o
);

  logic                        valid_q;
  logic [psbd_pkg::BYTE_W-1:0] data_q;
  logic                        last_q;

  // The register can load when empty or when its byte leaves this cycle.
  assign free_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= result_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && result_i.valid) begin
      data_q <= result_i.data_byte;
      last_q <= result_i.end_of_message;
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;
  assign m_last_o  = last_q;

endmodule

`default_nettype wire

FILE: rtl/preamble_sync_byte_deframer.sv
// The last bit of a byte waits in the input register; the byte then goes
// to the output register. Throughput: one bit per cycle while the sink takes
// each byte; a byte held by a stalled sink holds the input bit behind it. Reset
// (rst_ni low, asynchronous) empties both registers, returns to preamble hunt
// with a cleared shifter and count, and loads the preamble byte 0xAB.
// Depends on psbd_pkg.
`default_nettype none

module preamble_sync_byte_deframer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [psbd_pkg::BYTE_W-1:0] cfg_wdata_i,     // preamble_byte
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,    // [0] rx_bit, [7:1] zero
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [psbd_pkg::BYTE_W-1:0]      m_axis_tdata,    // [7:0] data_byte
  output logic                             m_axis_tlast     // end_of_message
);

  psbd_pkg::in_item_t item;
  psbd_pkg::result_t  result;
  logic               out_free;

  psbd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_bit_i   (s_axis_tdata[0]),
    .advance_i (out_free),
    .s_ready_o (s_axis_tready),
    .item_o    (item)
  );

  psbd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .advance_i   (out_free),
    .result_o    (result)
  );

  psbd_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .result_i  (result),
    .m_ready_i (m_axis_tready),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/psbd_checker.sv
// Port-level checker for the deframer, attached to the top level by bind.
// Depends on psbd_pkg and the assertion macro header.
`default_nettype none
`include "preamble_sync_byte_deframer_assert.svh"

module psbd_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [psbd_pkg::BYTE_W-1:0] m_axis_tdata,
  input wire logic                        m_axis_tlast
);

  // A stalled result keeps its byte and marker.
  `PSBD_ASSERT_IF(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled output changed")

  // The end marker is set exactly on the zero terminator.
  `PSBD_ASSERT_IF(a_last_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast == (m_axis_tdata == psbd_pkg::ZERO_BYTE), "end marker does not match zero byte")

  // The input side only stalls behind a full, blocked output register.
  `PSBD_ASSERT_IF(a_ready_cause, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

  // An empty output register never blocks the source.
  `PSBD_ASSERT_IF(a_ready_idle, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input not ready while output empty")

endmodule

bind preamble_sync_byte_deframer psbd_checker u_psbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
